// ----- hw/rtl/imh_pkg.sv -----
package imh_pkg;

  localparam int DEF_ELEMENTS = 4096;
  localparam int DEF_KEY_BITS = 32;

  localparam int FUNC_W  = 2;
  localparam int ELEM_W  = 12;
  localparam int POS_W   = 12;
  localparam int KEY_W   = 32;
  localparam int CNT_W   = 13;
  localparam int IN_W    = 64;
  localparam int OUT_W   = 64;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_REMOVE = 2'd1,
    FN_SETKEY = 2'd2,
    FN_NOP    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_QUEUED  = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INS,
    S_SET,
    S_RM_A,
    S_RM_B,
    S_UP,
    S_UP_CMP,
    S_DN,
    S_DN_L,
    S_DN_R,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t            status;
    logic [ELEM_W-1:0]  min_element;
    logic [KEY_W-1:0]   min_key;
    logic [CNT_W-1:0]   count;
  } imh_result_t;

endpackage

// ----- hw/rtl/indexed_min_heap_unit.sv -----
// Indexed binary min-heap: one operation per input item (insert, remove at heap position,
// set key with sift up, or no-op), one result item per operation carrying status, the heap
// top and the count. Heap entries {element, key} live in one single-port-write RAM, the
// element-to-position map with its queued flag in a second one; both have registered reads, so
// each operation runs as a read-compare-write sequence over the heap levels. After reset the
// position map is cleared entry by entry before the first item is taken. An insert or set key
// sifts its entry up; a remove moves the last entry into the freed position and sifts it up or
// down. A new item is taken only while the controller is idle and the result register is empty
// or being read.
module indexed_min_heap_unit
  import imh_pkg::*;
#(
  parameter int ELEMENTS = DEF_ELEMENTS,
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // func, element, position, key
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // status, min_element, min_key, count
);

  localparam int IW = $clog2(ELEMENTS);
  localparam int HW = IW + KEY_BITS;
  localparam int SW = IW + 1;

  logic              cmd_ready;
  logic              res_valid;
  imh_result_t       res;
  logic              hp_we;
  logic [IW-1:0]     hp_waddr, hp_raddr;
  logic [HW-1:0]     hp_wdata, hp_rdata;
  logic              sl_we;
  logic [IW-1:0]     sl_waddr, sl_raddr;
  logic [SW-1:0]     sl_wdata, sl_rdata;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r;

  assign in_tready = cmd_ready && (!out_valid_r || out_tready);

  imh_ctrl #(
    .ELEMENTS (ELEMENTS),
    .KEY_BITS (KEY_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (in_tvalid && in_tready),
    .cmd_func     (func_t'(in_tdata[1:0])),
    .cmd_element  (in_tdata[13:2]),
    .cmd_position (in_tdata[25:14]),
    .cmd_key      (KEY_BITS'(in_tdata[57:26])),
    .cmd_ready    (cmd_ready),
    .res_valid    (res_valid),
    .res          (res),
    .hp_we        (hp_we),
    .hp_waddr     (hp_waddr),
    .hp_wdata     (hp_wdata),
    .hp_raddr     (hp_raddr),
    .hp_rdata     (hp_rdata),
    .sl_we        (sl_we),
    .sl_waddr     (sl_waddr),
    .sl_wdata     (sl_wdata),
    .sl_raddr     (sl_raddr),
    .sl_rdata     (sl_rdata)
  );

  imh_ram #(
    .WIDTH (HW),
    .DEPTH (ELEMENTS)
  ) u_heap_ram (
    .clk   (clk),
    .we    (hp_we),
    .waddr (hp_waddr),
    .wdata (hp_wdata),
    .raddr (hp_raddr),
    .rdata (hp_rdata)
  );

  imh_ram #(
    .WIDTH (SW),
    .DEPTH (ELEMENTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (sl_we),
    .waddr (sl_waddr),
    .wdata (sl_wdata),
    .raddr (sl_raddr),
    .rdata (sl_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= {5'b0, res.count, res.min_key, res.min_element, res.status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- hw/rtl/imh_ram.sv -----
module imh_ram
  import imh_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/imh_ctrl.sv -----
module imh_ctrl
  import imh_pkg::*;
#(
  parameter int ELEMENTS = DEF_ELEMENTS,
  parameter int KEY_BITS = DEF_KEY_BITS,
  localparam int IW = $clog2(ELEMENTS),
  localparam int CW = $clog2(ELEMENTS + 1),
  localparam int HW = IW + KEY_BITS,
  localparam int SW = IW + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  func_t               cmd_func,
  input  logic [ELEM_W-1:0]   cmd_element,
  input  logic [POS_W-1:0]    cmd_position,
  input  logic [KEY_BITS-1:0] cmd_key,
  output logic                cmd_ready,
  output logic                res_valid,
  output imh_result_t         res,
  output logic                hp_we,
  output logic [IW-1:0]       hp_waddr,
  output logic [HW-1:0]       hp_wdata,
  output logic [IW-1:0]       hp_raddr,
  input  logic [HW-1:0]       hp_rdata,
  output logic                sl_we,
  output logic [IW-1:0]       sl_waddr,
  output logic [SW-1:0]       sl_wdata,
  output logic [IW-1:0]       sl_raddr,
  input  logic [SW-1:0]       sl_rdata
);

  state_t              state_r, state_nxt;
  status_t             status_r, status_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [IW-1:0]       pos_r, pos_nxt;
  logic [IW-1:0]       clr_r, clr_nxt;
  logic [IW-1:0]       mv_elem_r, mv_elem_nxt;
  logic [KEY_BITS-1:0] mv_key_r, mv_key_nxt;
  logic [HW-1:0]       left_r, left_nxt;
  logic [HW-1:0]       gone_r, gone_nxt;
  logic [IW-1:0]       top_elem_r;
  logic [KEY_BITS-1:0] top_key_r;

  logic [IW-1:0]       rd_elem;
  logic [KEY_BITS-1:0] rd_key;
  logic [KEY_BITS-1:0] left_key;
  logic [KEY_BITS-1:0] gone_key;
  logic [IW-1:0]       parent;
  logic [IW+1:0]       lchild;
  logic [IW+1:0]       rchild;
  logic [HW-1:0]       child;
  logic [IW-1:0]       child_pos;
  logic                child_ok;
  logic [IW-1:0]       last;

  assign rd_elem   = hp_rdata[HW-1:KEY_BITS];
  assign rd_key    = hp_rdata[KEY_BITS-1:0];
  assign left_key  = left_r[KEY_BITS-1:0];
  assign gone_key  = gone_r[KEY_BITS-1:0];
  assign parent    = IW'((pos_r - IW'(1)) >> 1);
  assign lchild    = {1'b0, pos_r, 1'b1};
  assign rchild    = lchild + (IW+2)'(1);
  assign last      = IW'(cnt_r - CW'(1));
  assign cmd_ready = (state_r == S_IDLE);

  // right child wins ties
  always_comb begin
    child     = left_r;
    child_pos = IW'(lchild);
    child_ok  = 1'b0;
    if (state_r == S_DN_R) begin
      child_ok = 1'b1;
      if (!(left_key < rd_key)) begin
        child     = hp_rdata;
        child_pos = IW'(rchild);
      end
    end else if (state_r == S_DN_L) begin
      child = hp_rdata;
      child_ok = !(rchild < (IW+2)'(cnt_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      cnt_r      <= '0;
      clr_r      <= '0;
      status_r   <= ST_OK;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      clr_r      <= clr_nxt;
      status_r   <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    mv_elem_r <= mv_elem_nxt;
    mv_key_r  <= mv_key_nxt;
    left_r    <= left_nxt;
    gone_r    <= gone_nxt;
    if (hp_we && hp_waddr == '0) begin
      top_elem_r <= hp_wdata[HW-1:KEY_BITS];
      top_key_r  <= hp_wdata[KEY_BITS-1:0];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    status_nxt  = status_r;
    cnt_nxt     = cnt_r;
    pos_nxt     = pos_r;
    clr_nxt     = clr_r;
    mv_elem_nxt = mv_elem_r;
    mv_key_nxt  = mv_key_r;
    left_nxt    = left_r;
    gone_nxt    = gone_r;
    hp_we       = 1'b0;
    hp_waddr    = pos_r;
    hp_wdata    = {mv_elem_r, mv_key_r};
    hp_raddr    = pos_r;
    sl_we       = 1'b0;
    sl_waddr    = mv_elem_r;
    sl_wdata    = {1'b1, pos_r};
    sl_raddr    = IW'(cmd_element);
    res_valid   = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        sl_we    = 1'b1;
        sl_waddr = clr_r;
        sl_wdata = '0;
        clr_nxt  = clr_r + IW'(1);
        if (clr_r == IW'(ELEMENTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        hp_raddr = IW'(cmd_position);
        if (cmd_valid) begin
          mv_elem_nxt = IW'(cmd_element);
          mv_key_nxt  = cmd_key;
          pos_nxt     = IW'(cmd_position);
          status_nxt  = ST_INVALID;
          state_nxt   = S_DONE;
          unique case (cmd_func)
            FN_INSERT: begin
              if (32'(cmd_element) < ELEMENTS) begin
                state_nxt = S_INS;
              end
            end
            FN_SETKEY: begin
              if (32'(cmd_element) < ELEMENTS) begin
                state_nxt = S_SET;
              end
            end
            FN_REMOVE: begin
              if (32'(cmd_position) < 32'(cnt_r)) begin
                state_nxt = S_RM_A;
              end
            end
            FN_NOP: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_INS: begin
        if (sl_rdata[SW-1]) begin
          status_nxt = ST_QUEUED;
          state_nxt  = S_DONE;
        end else if (cnt_r == CW'(ELEMENTS)) begin
          state_nxt = S_DONE;
        end else begin
          status_nxt = ST_OK;
          pos_nxt    = IW'(cnt_r);
          cnt_nxt    = cnt_r + CW'(1);
          state_nxt  = S_UP;
        end
      end
      S_SET: begin
        if (sl_rdata[SW-1]) begin
          status_nxt = ST_OK;
          pos_nxt    = sl_rdata[IW-1:0];
          state_nxt  = S_UP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RM_A: begin
        gone_nxt  = hp_rdata;
        hp_raddr  = last;
        state_nxt = S_RM_B;
      end
      S_RM_B: begin
        sl_we       = 1'b1;
        sl_waddr    = gone_r[HW-1:KEY_BITS];
        sl_wdata    = '0;
        cnt_nxt     = cnt_r - CW'(1);
        status_nxt  = ST_OK;
        mv_elem_nxt = rd_elem;
        mv_key_nxt  = rd_key;
        if (pos_r == last) begin
          state_nxt = S_DONE;
        end else if (rd_key < gone_key) begin
          state_nxt = S_UP;
        end else begin
          state_nxt = S_DN;
        end
      end
      S_UP: begin
        hp_raddr = parent;
        if (pos_r == '0) begin
          hp_we     = 1'b1;
          sl_we     = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        hp_we = 1'b1;
        sl_we = 1'b1;
        if (mv_key_r < rd_key) begin
          hp_wdata  = hp_rdata;
          sl_waddr  = rd_elem;
          pos_nxt   = parent;
          state_nxt = S_UP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DN: begin
        hp_raddr = IW'(lchild);
        if (!(lchild < (IW+2)'(cnt_r))) begin
          hp_we     = 1'b1;
          sl_we     = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DN_L;
        end
      end
      S_DN_L, S_DN_R: begin
        hp_raddr = IW'(rchild);
        if (state_r == S_DN_L) begin
          left_nxt = hp_rdata;
        end
        if (!child_ok) begin
          state_nxt = S_DN_R;
        end else begin
          hp_we = 1'b1;
          sl_we = 1'b1;
          if (mv_key_r < child[KEY_BITS-1:0]) begin
            state_nxt = S_DONE;
          end else begin
            hp_wdata  = child;
            sl_waddr  = child[HW-1:KEY_BITS];
            pos_nxt   = child_pos;
            state_nxt = S_DN;
          end
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.status      = status_r;
    res.count       = CNT_W'(cnt_r);
    res.min_element = '0;
    res.min_key     = '0;
    if (cnt_r != '0) begin
      res.min_element = ELEM_W'(top_elem_r);
      res.min_key     = KEY_W'(top_key_r);
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(ELEMENTS))
    else $error("count exceeds capacity");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !hp_we && !sl_we)
    else $error("memory write while idle");

  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> state_r == S_IDLE)
    else $error("result not followed by idle");

  a_cnt_change: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != $past(cnt_r) |-> $past(state_r) == S_INS || $past(state_r) == S_RM_B)
    else $error("count changed outside insert or remove");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top
  import imh_pkg::*;
();

  typedef struct packed {
    logic [12:0] count;
    logic [31:0] min_key;
    logic [11:0] min_element;
    logic [1:0]  status;
  } heap_res_t;

  class heap_scoreboard;
    logic [11:0] slots[4096];
    logic [12:0] pos_of[4096];
    bit          queued[4096];
    logic [31:0] keys[4096];
    int          fill;
    heap_res_t   pending[$];
    int          errors;

    function new();
      fill = 0;
      errors = 0;
      foreach (queued[i]) queued[i] = 0;
      foreach (keys[i]) keys[i] = '0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function void place(int p, logic [11:0] e);
      slots[p] = e;
      pos_of[e] = 13'(p);
    endfunction

    function void climb(int p);
      int up;
      logic [11:0] a, b;
      while (p > 0) begin
        up = (p - 1) / 2;
        a = slots[p];
        b = slots[up];
        if (!(keys[a] < keys[b])) break;
        place(p, b);
        place(up, a);
        p = up;
      end
    endfunction

    function void sink(int p);
      int l, r, c;
      logic [11:0] a, b;
      forever begin
        l = 2 * p + 1;
        r = l + 1;
        if (l >= fill) break;
        c = l;
        if (r < fill && !(keys[slots[l]] < keys[slots[r]])) c = r;
        a = slots[p];
        b = slots[c];
        if (keys[a] < keys[b]) break;
        place(p, b);
        place(c, a);
        p = c;
      end
    endfunction

    function void note_op(logic [1:0] fn, logic [11:0] el, logic [11:0] ps, logic [31:0] k);
      heap_res_t r;
      int last;
      logic [11:0] gone, mover;
      r.status = ST_INVALID;
      case (fn)
        FN_INSERT: begin
          if (queued[el]) r.status = ST_QUEUED;
          else if (fill < 4096) begin
            keys[el] = k;
            queued[el] = 1;
            place(fill, el);
            fill++;
            climb(fill - 1);
            r.status = ST_OK;
          end
        end
        FN_REMOVE: begin
          if (int'(ps) < fill) begin
            last = fill - 1;
            gone = slots[ps];
            mover = slots[last];
            place(int'(ps), mover);
            fill--;
            queued[gone] = 0;
            if (int'(ps) != last) begin
              if (keys[mover] < keys[gone]) climb(int'(ps));
              else sink(int'(ps));
            end
            r.status = ST_OK;
          end
        end
        FN_SETKEY: begin
          keys[el] = k;
          if (queued[el]) begin
            climb(int'(pos_of[el]));
            r.status = ST_OK;
          end
        end
        default: ;
      endcase
      r.min_element = fill > 0 ? slots[0] : '0;
      r.min_key = fill > 0 ? keys[slots[0]] : '0;
      r.count = 13'(fill);
      pending.push_back(r);
    endfunction

    function void check_result(heap_res_t got);
      heap_res_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item %h", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: exp st=%0d el=%0d key=%h cnt=%0d",
                    " got st=%0d el=%0d key=%h cnt=%0d"},
                   exp.status, exp.min_element, exp.min_key, exp.count,
                   got.status, got.min_element, got.min_key, got.count);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_W-1:0] out_tdata;

  heap_scoreboard sb = new();
  int cycles = 0;
  bit calm = 0;

  indexed_min_heap_unit dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("Test completed with failures");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(heap_res_t'(out_tdata[58:0]));
  end

  initial begin
    int n;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 0;
        n = $urandom_range(1, 15);
        repeat (n - 1) @(negedge clk);
      end else out_tready <= 1;
    end
  end

  task automatic send_op(logic [1:0] fn, logic [11:0] el, logic [11:0] ps, logic [31:0] k);
    if (!calm && $urandom_range(0, 6) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {6'd0, k, ps, el, fn};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_op(fn, el, ps, k);
    @(negedge clk);
  endtask

  logic [11:0] live[$];

  function automatic logic [11:0] pick_elem();
    if (live.size() > 0 && $urandom_range(0, 3) != 0)
      return live[$urandom_range(0, live.size() - 1)];
    return $urandom_range(0, 63) == 0 ? 12'($urandom) : 12'($urandom_range(0, 40));
  endfunction

  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: return 32'hFFFFFFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int fn, w;
    logic [11:0] e;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    send_op(FN_REMOVE, 12'd0, 12'd0, 32'd0);
    send_op(FN_SETKEY, 12'd5, 12'd0, 32'd100);
    send_op(FN_INSERT, 12'd0, 12'd0, 32'hFFFFFFFF);
    send_op(FN_INSERT, 12'd4095, 12'd4095, 32'd0);
    send_op(FN_INSERT, 12'd4095, 12'd0, 32'd9);
    send_op(FN_INSERT, 12'd7, 12'd0, 32'd0);
    send_op(FN_INSERT, 12'd8, 12'd0, 32'd50);
    send_op(FN_INSERT, 12'd9, 12'd0, 32'd50);
    send_op(FN_INSERT, 12'd10, 12'd0, 32'd50);
    send_op(FN_INSERT, 12'd5, 12'd0, 32'h12345678);
    send_op(FN_SETKEY, 12'd0, 12'd0, 32'd1);
    send_op(FN_SETKEY, 12'd7, 12'd0, 32'hFFFF0000);
    send_op(FN_NOP, 12'hFFF, 12'hFFF, 32'hFFFFFFFF);
    send_op(FN_REMOVE, 12'd0, 12'd4095, 32'd0);
    send_op(FN_REMOVE, 12'd0, 12'd6, 32'd0);
    send_op(FN_REMOVE, 12'd0, 12'd0, 32'd0);
    send_op(FN_REMOVE, 12'd0, 12'd1, 32'd0);
    send_op(FN_REMOVE, 12'd0, 12'd3, 32'd0);
    for (int i = 0; i < 850; i++) begin
      if (i > 760) calm = 1;
      fn = $urandom_range(0, 19);
      w = (i / 100) % 2;
      if (fn < (w ? 6 : 10)) begin
        e = pick_elem();
        send_op(FN_INSERT, e, 12'($urandom), rand_key());
      end else if (fn < 16) begin
        send_op(FN_REMOVE, 12'($urandom), $urandom_range(0, 3) == 0 ? 12'($urandom)
                : 12'($urandom_range(0, sb.fill > 0 ? sb.fill - 1 : 0)), 32'($urandom));
      end else if (fn < 19) begin
        send_op(FN_SETKEY, pick_elem(), 12'($urandom), rand_key());
      end else send_op(FN_NOP, 12'($urandom), 12'($urandom), 32'($urandom));
      if (i % 50 == 0) begin
        live.delete();
        for (int j = 0; j < 4096; j++) if (sb.queued[j]) live.push_back(12'(j));
      end
    end
    in_tvalid <= 0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

// ----- files.f -----
hw/rtl/imh_pkg.sv
hw/rtl/imh_ram.sv
hw/rtl/imh_ctrl.sv
hw/rtl/indexed_min_heap_unit.sv
tb/tb_top.sv
